// ----- rtl/nars_pkg.sv -----
// Shared types, constants and field widths of the eight-neighbour relaxation core.
package nars_pkg;

	// Grid geometry limits
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MIN_DIM     = 3;
	localparam int COL_BITS    = 10;
	localparam int ROW_BITS    = 12;
	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 13;
	localparam int CFG_BITS    = 13;

	// Cell value format: signed Q8.8
	localparam int VAL_BITS = 16;
	localparam int NBR      = 8;
	localparam int SUM_BITS = VAL_BITS + 3;

	// Rounded division by 3, 5 or 8 as multiply by reciprocal, then shift
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_BITS  = 19;
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
	localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
	localparam logic [RECIP_BITS-1:0] RECIP_3 = 19'd349526;
	localparam logic [RECIP_BITS-1:0] RECIP_5 = 19'd209716;
	localparam logic [RECIP_BITS-1:0] RECIP_8 = 19'd131072;

	// Job queue between front and back
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	// Stream payload widths
	localparam int IN_TDATA_BITS  = 16;
	localparam int OUT_TDATA_BITS = 40;
	localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - VAL_BITS - COL_BITS - ROW_BITS;

	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_DRAIN = 1'b1
	} nars_op_t;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} nars_reg_t;

	typedef enum logic [1:0] {
		DIV_BY_8 = 2'd0,
		DIV_BY_5 = 2'd1,
		DIV_BY_3 = 2'd2
	} nars_div_t;

	typedef logic signed [VAL_BITS-1:0] nars_val_t;

	// Position and frame marker of one result
	typedef struct packed {
		logic [COL_BITS-1:0] column;
		logic [ROW_BITS-1:0] row;
		logic                last;
	} nars_tag_t;

	// One averaging job: neighbours in raster order around the centre
	typedef struct packed {
		nars_val_t [NBR-1:0] nbr;
		logic [NBR-1:0]      mask;
		nars_div_t           div;
		nars_tag_t           tag;
	} nars_job_t;

endpackage

// ----- rtl/neighbour_average_relaxation_step_core.sv -----
// Top level of the eight-neighbour relaxation core: front, job queue and back.
//
// Usage: cells of one grid frame enter on the s_ stream in raster order
// (s_tuser = 0, s_tdata = old Q8.8 value). Each result on the m_ stream is
// the rounded mean of the existing neighbours of one cell, centre excluded,
// with its column and row; m_tlast marks the final cell of the frame.
// The result for cell (r, c) is released by the input cell one row plus one
// cell later; after the last cell, grid_width + 1 drain items (s_tuser = 1)
// take out the remaining results. Drains with nothing pending, and cells
// sent while a frame still drains, are dropped without a result.
// Path of a released result after the releasing transaction: row store read,
// window, queue, sum, reciprocal multiply and output register, in that order.
// Throughput: one transaction per cycle on each side while the receiver keeps
// up, set by the single row store port pair and the four-entry job queue.
// Configuration: cfg_index 0 = grid_width, 1 = grid_height, written while
// the core is idle; a write restarts the frame.
// Reset clears positions, queue and pipeline; sizes return to 1024 x 4096.
// A stalled receiver holds the output register and fills the queue, after
// which s_tready drops until room frees up.
module neighbour_average_relaxation_step_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nars_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [15:0] cell_value
	input  logic [0:0]                          s_tuser,   // [0] operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nars_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [15:0] new_value, [25:16] column,
	                                                       // [37:26] row, [39:38] zero
	output logic                                m_tlast,   // last_of_frame
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [nars_pkg::CFG_BITS-1:0]       cfg_data
);

	logic                           push;
	nars_pkg::nars_job_t            push_job;
	logic                           pop;
	logic                           head_valid;
	nars_pkg::nars_job_t            head_job;
	logic [nars_pkg::QCNT_BITS-1:0] q_count;

	nars_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (push),
		.push_job  (push_job)
	);

	nars_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.count      (q_count)
	);

	nars_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- rtl/nars_front.sv -----
// Front part: configuration, input classification, row stores and 3x3 window.
module nars_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nars_pkg::IN_TDATA_BITS-1:0] s_tdata,
	input  logic [0:0]                      s_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [nars_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic [nars_pkg::QCNT_BITS-1:0]  q_count,
	output logic                            push,
	output nars_pkg::nars_job_t             push_job
);

	// Configuration and position registers
	logic [nars_pkg::WIDTH_BITS-1:0]  width_q;
	logic [nars_pkg::HEIGHT_BITS-1:0] height_q;
	logic [nars_pkg::COL_BITS-1:0]    in_col_q;
	logic [nars_pkg::ROW_BITS-1:0]    in_row_q;
	logic [nars_pkg::COL_BITS-1:0]    out_col_q;
	logic [nars_pkg::ROW_BITS-1:0]    out_row_q;

	// Row stores
	nars_pkg::nars_val_t upper_mem [nars_pkg::MAX_WIDTH];
	nars_pkg::nars_val_t middle_mem [nars_pkg::MAX_WIDTH];

	// Window, [row][col], column 2 newest
	nars_pkg::nars_val_t win_q [3][3];

	// Stage 1 registers
	logic                          valid_s1;
	logic                          cell_s1;
	logic                          emit_s1;
	logic                          pre_zero_s1;
	logic                          zero_col_s1;
	logic [nars_pkg::COL_BITS-1:0] addr_s1;
	nars_pkg::nars_val_t           value_s1;
	nars_pkg::nars_val_t           rd_upper_s1;
	nars_pkg::nars_val_t           rd_middle_s1;
	logic [nars_pkg::NBR-1:0]      mask_s1;
	nars_pkg::nars_div_t           div_s1;
	nars_pkg::nars_tag_t           tag_s1;

	// Stage 0 classification
	logic                             accept;
	logic                             is_drain;
	logic                             draining;
	logic                             take;
	logic                             emit0;
	logic                             pre_zero0;
	logic                             zero_col0;
	logic                             special;
	logic [nars_pkg::COL_BITS-1:0]    rd_addr0;
	logic                             rd_en0;
	nars_pkg::nars_val_t              value0;
	logic [nars_pkg::WIDTH_BITS-1:0]  out_col_next;
	logic [nars_pkg::HEIGHT_BITS-1:0] out_row_next;
	logic [nars_pkg::WIDTH_BITS-1:0]  in_col_next;
	logic [nars_pkg::HEIGHT_BITS-1:0] in_row_next;
	logic                             top_ok;
	logic                             bot_ok;
	logic                             left_ok;
	logic                             right_ok;
	logic                             last0;
	logic [2:0]                       missing;
	logic [nars_pkg::NBR-1:0]         mask0;
	nars_pkg::nars_div_t              div0;
	logic [nars_pkg::QCNT_BITS:0]     occupancy;
	logic [nars_pkg::WIDTH_BITS-1:0]  width_raw;
	logic [nars_pkg::HEIGHT_BITS-1:0] height_raw;
	logic [nars_pkg::WIDTH_BITS-1:0]  width_sat;
	logic [nars_pkg::HEIGHT_BITS-1:0] height_sat;
	nars_pkg::nars_val_t              new_col [3];

	assign cfg_ready = 1'b1;

	// Clamp register writes to the supported grid sizes
	always_comb begin
		width_raw  = cfg_data[nars_pkg::WIDTH_BITS-1:0];
		height_raw = cfg_data[nars_pkg::HEIGHT_BITS-1:0];
		if (width_raw < nars_pkg::WIDTH_BITS'(nars_pkg::MIN_DIM)) begin
			width_sat = nars_pkg::WIDTH_BITS'(nars_pkg::MIN_DIM);
		end else if (width_raw > nars_pkg::WIDTH_BITS'(nars_pkg::MAX_WIDTH)) begin
			width_sat = nars_pkg::WIDTH_BITS'(nars_pkg::MAX_WIDTH);
		end else begin
			width_sat = width_raw;
		end
		if (height_raw < nars_pkg::HEIGHT_BITS'(nars_pkg::MIN_DIM)) begin
			height_sat = nars_pkg::HEIGHT_BITS'(nars_pkg::MIN_DIM);
		end else if (height_raw > nars_pkg::HEIGHT_BITS'(nars_pkg::MAX_HEIGHT)) begin
			height_sat = nars_pkg::HEIGHT_BITS'(nars_pkg::MAX_HEIGHT);
		end else begin
			height_sat = height_raw;
		end
	end

	// Reserve a queue slot for the job still in stage 1
	assign push      = valid_s1 && emit_s1;
	assign occupancy = {1'b0, q_count} + {{nars_pkg::QCNT_BITS{1'b0}}, push};
	assign s_tready  = occupancy < (nars_pkg::QCNT_BITS + 1)'(nars_pkg::QDEPTH);
	assign accept    = s_tvalid && s_tready;

	// Classify the item against the frame positions
	always_comb begin
		is_drain     = nars_pkg::nars_op_t'(s_tuser[0]) == nars_pkg::OP_DRAIN;
		draining     = (in_col_q == '0) && (in_row_q == '0) &&
		               ((out_col_q != '0) || (out_row_q != '0));
		take         = accept && (is_drain == draining);
		out_col_next = {1'b0, out_col_q} + nars_pkg::WIDTH_BITS'(1);
		out_row_next = {1'b0, out_row_q} + nars_pkg::HEIGHT_BITS'(1);
		in_col_next  = {1'b0, in_col_q} + nars_pkg::WIDTH_BITS'(1);
		in_row_next  = {1'b0, in_row_q} + nars_pkg::HEIGHT_BITS'(1);
		top_ok       = out_row_q != '0;
		left_ok      = out_col_q != '0;
		right_ok     = out_col_next < width_q;
		bot_ok       = out_row_next < height_q;
		last0        = !bot_ok && !right_ok;
		special      = ((out_row_next + nars_pkg::HEIGHT_BITS'(1)) == height_q) && !right_ok;
		if (is_drain) begin
			emit0     = 1'b1;
			pre_zero0 = special;
			zero_col0 = !special && !right_ok;
			rd_addr0  = special ? '0 : out_col_next[nars_pkg::COL_BITS-1:0];
			value0    = '0;
		end else begin
			emit0     = (in_col_q == '0) ? (in_row_q >= nars_pkg::ROW_BITS'(2))
			                             : (in_row_q != '0);
			pre_zero0 = in_col_q == '0;
			zero_col0 = 1'b0;
			rd_addr0  = in_col_q;
			value0    = nars_pkg::nars_val_t'(s_tdata[nars_pkg::VAL_BITS-1:0]);
		end
		rd_en0 = take && !zero_col0;
	end

	// Pick the neighbours that exist and the divisor they give
	always_comb begin
		mask0[0] = top_ok && left_ok;
		mask0[1] = top_ok;
		mask0[2] = top_ok && right_ok;
		mask0[3] = left_ok;
		mask0[4] = right_ok;
		mask0[5] = bot_ok && left_ok;
		mask0[6] = bot_ok;
		mask0[7] = bot_ok && right_ok;
		missing  = 3'(!top_ok) + 3'(!bot_ok) + 3'(!left_ok) + 3'(!right_ok);
		if (missing == 3'd0) begin
			div0 = nars_pkg::DIV_BY_8;
		end else if (missing == 3'd1) begin
			div0 = nars_pkg::DIV_BY_5;
		end else begin
			div0 = nars_pkg::DIV_BY_3;
		end
	end

	// Advance the input and output positions; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= nars_pkg::WIDTH_BITS'(nars_pkg::MAX_WIDTH);
			height_q  <= nars_pkg::HEIGHT_BITS'(nars_pkg::MAX_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (cfg_valid && cfg_ready) begin
				if (nars_pkg::nars_reg_t'(cfg_index) == nars_pkg::REG_GRID_WIDTH) begin
					width_q <= width_sat;
				end else begin
					height_q <= height_sat;
				end
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (take) begin
				if (!is_drain) begin
					if (in_col_next >= width_q) begin
						in_col_q <= '0;
						in_row_q <= (in_row_next >= height_q) ? '0
						            : in_row_next[nars_pkg::ROW_BITS-1:0];
					end else begin
						in_col_q <= in_col_next[nars_pkg::COL_BITS-1:0];
					end
				end
				if (emit0) begin
					if (last0) begin
						out_col_q <= '0;
						out_row_q <= '0;
					end else if (!right_ok) begin
						out_col_q <= '0;
						out_row_q <= out_row_next[nars_pkg::ROW_BITS-1:0];
					end else begin
						out_col_q <= out_col_next[nars_pkg::COL_BITS-1:0];
					end
				end
			end
		end
	end

	// Hold the classified item for stage 1
	always_ff @(posedge clk) begin
		if (take) begin
			cell_s1     <= !is_drain;
			emit_s1     <= emit0;
			pre_zero_s1 <= pre_zero0;
			zero_col_s1 <= zero_col0;
			addr_s1     <= rd_addr0;
			value_s1    <= value0;
			mask_s1     <= mask0;
			div_s1      <= div0;
			tag_s1      <= '{column: out_col_q, row: out_row_q, last: last0};
		end
	end

	// Upper row store: read in stage 0, take the old middle entry in stage 1
	always_ff @(posedge clk) begin
		if (rd_en0) begin
			rd_upper_s1 <= upper_mem[rd_addr0];
		end
		if (valid_s1 && cell_s1) begin
			upper_mem[addr_s1] <= rd_middle_s1;
		end
	end

	// Middle row store: read in stage 0, take the new cell in stage 1
	always_ff @(posedge clk) begin
		if (rd_en0) begin
			rd_middle_s1 <= middle_mem[rd_addr0];
		end
		if (valid_s1 && cell_s1) begin
			middle_mem[addr_s1] <= value_s1;
		end
	end

	// Column entering the window
	always_comb begin
		new_col[0] = zero_col_s1 ? '0 : rd_upper_s1;
		new_col[1] = zero_col_s1 ? '0 : rd_middle_s1;
		new_col[2] = value_s1;
	end

	// Shift the window; a row start, or the drain that opens the last row, inserts a zero column first
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				if (pre_zero_s1) begin
					win_q[r][0] <= win_q[r][2];
					win_q[r][1] <= '0;
				end else begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[r][2] <= new_col[r];
			end
		end
	end

	// Build the job around the window centre
	always_comb begin
		push_job.nbr[0] = win_q[0][1];
		push_job.nbr[1] = win_q[0][2];
		push_job.nbr[2] = new_col[0];
		push_job.nbr[3] = win_q[1][1];
		push_job.nbr[4] = new_col[1];
		push_job.nbr[5] = win_q[2][1];
		push_job.nbr[6] = win_q[2][2];
		push_job.nbr[7] = new_col[2];
		push_job.mask   = mask_s1;
		push_job.div    = div_s1;
		push_job.tag    = tag_s1;
	end

`ifndef NO_ASSERTIONS
	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ($countones(push_job.mask) == 3 || $countones(push_job.mask) == 5 ||
		          $countones(push_job.mask) == 8))
		else $error("job neighbour count is not 3, 5 or 8");
	a_mask_div: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (($countones(push_job.mask) == 8) == (push_job.div == nars_pkg::DIV_BY_8)))
		else $error("job divisor disagrees with its neighbour mask");
	a_write_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cell_s1) |-> ({1'b0, addr_s1} < width_q))
		else $error("row store written beyond the grid width");
`endif

endmodule

// ----- rtl/nars_queue.sv -----
// Short job queue that decouples the front part from the averaging back part.
module nars_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  nars_pkg::nars_job_t            push_job,
	input  logic                           pop,
	output logic                           head_valid,
	output nars_pkg::nars_job_t            head_job,
	output logic [nars_pkg::QCNT_BITS-1:0] count
);

	nars_pkg::nars_job_t             entry_q [nars_pkg::QDEPTH];
	logic [nars_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [nars_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [nars_pkg::QCNT_BITS-1:0]  count_q;

	assign head_valid = count_q != '0;
	assign head_job   = entry_q[rd_ptr_q];
	assign count      = count_q;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + nars_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + nars_pkg::QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + nars_pkg::QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - nars_pkg::QCNT_BITS'(1);
			end
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q != nars_pkg::QCNT_BITS'(nars_pkg::QDEPTH)))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job queue underflow");
`endif

endmodule

// ----- rtl/nars_back.sv -----
// Back part: masked neighbour sum, rounded division by 3, 5 or 8, result register.
module nars_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  nars_pkg::nars_job_t                 head_job,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nars_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	output logic                                m_tlast
);

	logic                                  en;
	logic signed [nars_pkg::SUM_BITS-1:0]  sum0;

	logic                                  valid_s1;
	logic signed [nars_pkg::SUM_BITS-1:0]  sum_s1;
	nars_pkg::nars_div_t                   div_s1;
	nars_pkg::nars_tag_t                   tag_s1;

	logic                                  valid_s2;
	logic                                  neg_s2;
	logic [nars_pkg::SUM_BITS-1:0]         y_s2;
	logic [nars_pkg::RECIP_BITS-1:0]       recip_s2;
	nars_pkg::nars_tag_t                   tag_s2;

	logic                                  valid_s3;
	logic                                  neg_s3;
	logic [nars_pkg::PROD_BITS-1:0]        prod_s3;
	nars_pkg::nars_tag_t                   tag_s3;

	logic [nars_pkg::SUM_BITS-1:0]         mag1;
	logic [nars_pkg::SUM_BITS-1:0]         bias1;
	logic [nars_pkg::RECIP_BITS-1:0]       recip1;
	logic [nars_pkg::QUOT_BITS-1:0]        quot3;
	logic [nars_pkg::QUOT_BITS-1:0]        mean3;

	logic                                  m_tvalid_q;
	logic [nars_pkg::OUT_TDATA_BITS-1:0]   m_tdata_q;
	logic                                  m_tlast_q;

	// Advance the whole pipeline unless a result waits on the receiver
	assign en  = !m_tvalid_q || m_tready;
	assign pop = en && head_valid;

	// Sum the neighbours that exist
	always_comb begin
		sum0 = '0;
		for (int i = 0; i < nars_pkg::NBR; i++) begin
			if (head_job.mask[i]) begin
				sum0 = sum0 + nars_pkg::SUM_BITS'($signed(head_job.nbr[i]));
			end
		end
	end

	// Magnitude plus half the divisor, and the reciprocal to apply
	always_comb begin
		mag1 = sum_s1[nars_pkg::SUM_BITS-1] ? (~sum_s1 + nars_pkg::SUM_BITS'(1)) : sum_s1;
		case (div_s1)
			nars_pkg::DIV_BY_8: begin
				bias1  = nars_pkg::SUM_BITS'(4);
				recip1 = nars_pkg::RECIP_8;
			end
			nars_pkg::DIV_BY_5: begin
				bias1  = nars_pkg::SUM_BITS'(2);
				recip1 = nars_pkg::RECIP_5;
			end
			nars_pkg::DIV_BY_3: begin
				bias1  = nars_pkg::SUM_BITS'(1);
				recip1 = nars_pkg::RECIP_3;
			end
			default: begin
				bias1  = nars_pkg::SUM_BITS'(4);
				recip1 = nars_pkg::RECIP_8;
			end
		endcase
	end

	// Quotient from the product, sign restored
	always_comb begin
		quot3 = prod_s3[nars_pkg::PROD_BITS-1:nars_pkg::RECIP_SHIFT];
		mean3 = neg_s3 ? (~quot3 + nars_pkg::QUOT_BITS'(1)) : quot3;
	end

	// Pipeline valid bits and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			valid_s1   <= pop;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			m_tvalid_q <= valid_s3;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1    <= sum0;
			div_s1    <= head_job.div;
			tag_s1    <= head_job.tag;
			neg_s2    <= sum_s1[nars_pkg::SUM_BITS-1];
			y_s2      <= mag1 + bias1;
			recip_s2  <= recip1;
			tag_s2    <= tag_s1;
			neg_s3    <= neg_s2;
			prod_s3   <= nars_pkg::PROD_BITS'(y_s2) * nars_pkg::PROD_BITS'(recip_s2);
			tag_s3    <= tag_s2;
			m_tdata_q <= {{nars_pkg::OUT_PAD_BITS{1'b0}}, tag_s3.row, tag_s3.column,
			              mean3[nars_pkg::VAL_BITS-1:0]};
			m_tlast_q <= tag_s3.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- tb/relax_result_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts relaxation results from observed transactions and compares them.
module relax_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [nars_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [15:0] cell_value
	input  logic [0:0]                          s_tuser,   // [0] operation
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [nars_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [15:0] new_value, [25:16] column,
	                                                       // [37:26] row, [39:38] zero
	input  logic                                m_tlast,   // last_of_frame
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [nars_pkg::CFG_BITS-1:0]       cfg_data,
	output int                                  fail_count,
	output int                                  pending
);
	import nars_pkg::*;

	typedef struct packed {
		nars_val_t value;
		nars_tag_t tag;
	} cell_result_t;

	// Predicted copy of the core state
	logic [WIDTH_BITS-1:0]  width_reg;
	logic [HEIGHT_BITS-1:0] height_reg;
	nars_val_t              upper_row [MAX_WIDTH];
	nars_val_t              middle_row [MAX_WIDTH];
	int                     win [9];	// row*3 + col, col 2 newest
	int unsigned            in_col, in_row, out_col, out_row;
	cell_result_t           due_results [$];
	int                     mismatches;

	function automatic int unsigned width_used();
		int unsigned w;
		w = width_reg;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned height_used();
		int unsigned h;
		h = height_reg;
		if (h < MIN_DIM) h = MIN_DIM;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	task automatic slide_window(input int top, input int mid, input int low);
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = low;
	endtask

	// Average the existing neighbours of the output cell, queue it, advance
	task automatic average_neighbours(input int unsigned w, input int unsigned h);
		longint       total;
		longint       mag;
		longint       q;
		longint       mean;
		int           n;
		cell_result_t r;
		total = 0;
		n = 0;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				if (dy == 0 && out_row == 0) continue;
				if (dy == 2 && out_row + 1 >= h) continue;
				if (dy == 1 && dx == 1) continue;
				if (dx == 0 && out_col == 0) continue;
				if (dx == 2 && out_col + 1 >= w) continue;
				total += win[dy*3+dx];
				n++;
			end
		end
		// Round to nearest, ties away from zero
		mag  = (total < 0) ? -total : total;
		q    = (2 * mag + n) / (2 * n);
		mean = (total < 0) ? -q : q;
		r.value      = mean[VAL_BITS-1:0];
		r.tag.column = out_col[COL_BITS-1:0];
		r.tag.row    = out_row[ROW_BITS-1:0];
		r.tag.last   = (out_row + 1 >= h) && (out_col + 1 >= w);
		due_results.push_back(r);
		if (r.tag.last) begin
			out_row = 0;
			out_col = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endtask

	task automatic take_item(input nars_op_t op, input nars_val_t v);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned nx;
		bit          draining;
		w = width_used();
		h = height_used();
		draining = (in_row == 0 && in_col == 0) && (out_row != 0 || out_col != 0);
		if (op == OP_DRAIN) begin
			// Drain only releases results of a finished frame
			if (draining) begin
				if (out_row + 2 == h && out_col + 1 == w) begin
					slide_window(0, 0, 0);
					average_neighbours(w, h);
					slide_window(upper_row[0], middle_row[0], 0);
				end else begin
					nx = out_col + 1;
					if (nx < w)
						slide_window(upper_row[nx], middle_row[nx], 0);
					else
						slide_window(0, 0, 0);
					average_neighbours(w, h);
				end
			end
		end else if (!draining) begin
			c = in_col;
			if (c >= w) c = w - 1;
			if (c == 0) begin
				slide_window(0, 0, 0);
				if (in_row >= 2) average_neighbours(w, h);
				slide_window(upper_row[0], middle_row[0], v);
			end else begin
				slide_window(upper_row[c], middle_row[c], v);
				if (in_row >= 1) average_neighbours(w, h);
			end
			upper_row[c]  = middle_row[c];
			middle_row[c] = v;
			if (c + 1 >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) in_row = 0;
			end else begin
				in_col = c + 1;
			end
		end
	endtask

	task automatic check_result();
		cell_result_t              want;
		nars_val_t                 got_value;
		logic [COL_BITS-1:0]       got_col;
		logic [ROW_BITS-1:0]       got_row;
		logic [OUT_PAD_BITS-1:0]   got_pad;
		got_value = m_tdata[VAL_BITS-1:0];
		got_col   = m_tdata[VAL_BITS +: COL_BITS];
		got_row   = m_tdata[VAL_BITS+COL_BITS +: ROW_BITS];
		got_pad   = m_tdata[OUT_TDATA_BITS-1 -: OUT_PAD_BITS];
		if (due_results.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: value %0d col %0d row %0d last %0b",
					got_value, got_col, got_row, m_tlast);
			mismatches++;
		end else begin
			want = due_results.pop_front();
			if (got_value !== want.value || got_col !== want.tag.column ||
			    got_row !== want.tag.row || m_tlast !== want.tag.last || got_pad !== '0) begin
				if (mismatches < 10)
					$display({"mismatch: expected value %0d col %0d row %0d last %0b, ",
						"got value %0d col %0d row %0d last %0b pad %0h"},
						want.value, want.tag.column, want.tag.row, want.tag.last,
						got_value, got_col, got_row, m_tlast, got_pad);
				mismatches++;
			end
		end
	endtask

	// Follow every transaction on the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_BITS'(MAX_WIDTH);
			height_reg = HEIGHT_BITS'(MAX_HEIGHT);
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			for (int i = 0; i < 9; i++) win[i] = 0;
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
			due_results.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_WIDTH)
					width_reg = cfg_data[WIDTH_BITS-1:0];
				else
					height_reg = cfg_data[HEIGHT_BITS-1:0];
				in_col  = 0;
				in_row  = 0;
				out_col = 0;
				out_row = 0;
			end
			if (s_tvalid && s_tready)
				take_item(nars_op_t'(s_tuser), nars_val_t'(s_tdata));
			if (m_tvalid && m_tready)
				check_result();
			fail_count <= mismatches;
			pending    <= due_results.size();
		end
	end

endmodule

// ----- tb/tb_neighbour_average_relaxation_step_core.sv -----
`timescale 1ns / 1ps
// Testbench top: stimulus and verdict for the eight-neighbour relaxation core.
module tb_neighbour_average_relaxation_step_core;
	import nars_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_CELLS  = 500;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
	logic [0:0]                s_tuser   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      m_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index = 1'b0;
	logic [CFG_BITS-1:0]       cfg_data  = '0;

	int fail_count;
	int pending;
	bit burst     = 1'b0;	// no idling on either side while set
	int ready_run = 0;
	int cycles    = 0;
	int grid_w    = MAX_WIDTH;
	int grid_h    = MAX_HEIGHT;
	int cells_sent;

	neighbour_average_relaxation_step_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	relax_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[neighbour_average_relaxation_step_core] ERROR");
			$finish;
		end
	end

	function automatic int send_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst) return 0;
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(0, 2);
		if (r < 97) return $urandom_range(3, 10);
		return $urandom_range(20, 80);
	endfunction

	function automatic nars_val_t cell_pick();
		case ($urandom_range(0, 39))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			4:       return 16'h0001;
			default: return nars_val_t'($urandom);
		endcase
	endfunction

	function automatic int clamp_dim(input int v, input int hi);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > hi) return hi;
		return v;
	endfunction

	// Receiver: alternate ready runs and stalls of random length
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			ready_run <= 0;
		end else if (burst) begin
			m_tready <= 1'b1;
		end else if (ready_run > 0) begin
			ready_run <= ready_run - 1;
		end else if (m_tready) begin
			m_tready  <= 1'b0;
			ready_run <= stall_len();
		end else begin
			m_tready  <= 1'b1;
			ready_run <= $urandom_range(0, 30);
		end
	end

	task automatic send_item(input nars_op_t op, input nars_val_t v);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input nars_reg_t idx, input logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_grid(input bit do_w, input logic [CFG_BITS-1:0] w_data,
	                        input bit do_h, input logic [CFG_BITS-1:0] h_data);
		if (do_w) begin
			write_reg(REG_GRID_WIDTH, w_data);
			grid_w = clamp_dim(int'(w_data[WIDTH_BITS-1:0]), MAX_WIDTH);
		end
		if (do_h) begin
			write_reg(REG_GRID_HEIGHT, h_data);
			grid_h = clamp_dim(int'(h_data[HEIGHT_BITS-1:0]), MAX_HEIGHT);
		end
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender until every predicted result is out and the pipeline is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stream cells of one frame; optionally drain it, with dropped items mixed in
	task automatic run_frame(input int n_cells, input bit drain_all, input bit noisy);
		for (int i = 0; i < n_cells; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(OP_DRAIN, nars_val_t'($urandom));
			send_item(OP_CELL, cell_pick());
			cells_sent++;
		end
		if (drain_all) begin
			for (int i = 0; i <= grid_w; i++) begin
				if (noisy && $urandom_range(0, 9) == 0)
					send_item(OP_CELL, cell_pick());
				send_item(OP_DRAIN, nars_val_t'($urandom));
			end
			if (noisy && $urandom_range(0, 2) == 0)
				send_item(OP_DRAIN, nars_val_t'($urandom));
		end
	endtask

	initial begin
		int  w;
		int  h;
		int  wv;
		int  hv;
		int  which;
		int  frames;
		bit  abandoned;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest grid: corners at the negative extreme, edges at the positive
		// extreme; the centre sum then ties at minus one half
		set_grid(1'b1, CFG_BITS'(3), 1'b1, CFG_BITS'(3));
		send_item(OP_DRAIN, 16'h5a5a);
		for (int i = 0; i < 9; i++)
			send_item(OP_CELL, (i == 4) ? 16'h0000 : (i % 2 == 1) ? 16'h7fff : 16'h8000);
		send_item(OP_CELL, 16'h1234);
		repeat (4) send_item(OP_DRAIN, 16'hffff);
		send_item(OP_DRAIN, 16'h0000);

		// Clamped sizes, streamed without idling; both frames are cut short
		settle();
		burst = 1'b1;
		set_grid(1'b1, CFG_BITS'(2047), 1'b1, CFG_BITS'(8191));
		run_frame(MAX_WIDTH / 16, 1'b0, 1'b0);
		settle();
		set_grid(1'b1, CFG_BITS'(0), 1'b1, CFG_BITS'(MAX_HEIGHT));
		run_frame(3 * 20, 1'b0, 1'b0);
		burst = 1'b0;

		// Random small grids, back-to-back frames and abandoned frames
		cells_sent = 0;
		abandoned  = 1'b1;
		while (cells_sent < RANDOM_CELLS) begin
			settle();
			burst = ($urandom_range(0, 4) == 0);
			w = ($urandom_range(0, 99) < 70) ? $urandom_range(3, 6) :
			    ($urandom_range(0, 9) < 8) ? $urandom_range(7, 16) : $urandom_range(17, 40);
			h = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 6) : $urandom_range(7, 12);
			if (abandoned || $urandom_range(0, 2) != 0) begin
				wv = (w == 3 && $urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : w;
				hv = (h == 3 && $urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : h;
				// Set both sizes on the first random grid
				which = (cells_sent == 0) ? 0 : $urandom_range(0, 2);
				set_grid(which != 2, {2'($urandom_range(0, 3)), 11'(wv)},
				         which != 1, 13'(hv));
			end
			frames = $urandom_range(1, 2);
			abandoned = 1'b0;
			for (int f = 0; f < frames; f++) begin
				if ($urandom_range(0, 7) == 0) begin
					run_frame($urandom_range(1, grid_w * grid_h - 1), 1'b0, 1'b1);
					abandoned = 1'b1;
					break;
				end
				run_frame(grid_w * grid_h, 1'b1, 1'b1);
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("[neighbour_average_relaxation_step_core] OK");
		else
			$display("[neighbour_average_relaxation_step_core] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/nars_pkg.sv
rtl/nars_front.sv
rtl/nars_queue.sv
rtl/nars_back.sv
rtl/neighbour_average_relaxation_step_core.sv
tb/relax_result_checker.sv
tb/tb_neighbour_average_relaxation_step_core.sv
